// ===== rtl/core/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int ANG_W  = 34;
   localparam int OP_W   = 33;
   localparam int ROLL_W = 15;
   localparam int PITCH_W = 14;
   localparam int ANG_FRAC = 22;
   localparam int ANG_LIM = 11520;
   localparam int PITCH_LIM = 5760;

   typedef logic signed [ANG_W-1:0] ang_type;

   function automatic ang_type atan_entry(input int idx);
      ang_type t;
      case (idx)
         0: t = 34'sd188743680;  1: t = 34'sd111421900; 2: t = 34'sd58872272;
         3: t = 34'sd29884485;   4: t = 34'sd15000234;  5: t = 34'sd7507429;
         6: t = 34'sd3754631;    7: t = 34'sd1877430;   8: t = 34'sd938729;
         9: t = 34'sd469366;     10: t = 34'sd234683;   11: t = 34'sd117342;
         12: t = 34'sd58671;     13: t = 34'sd29335;    14: t = 34'sd14668;
         15: t = 34'sd7334;      16: t = 34'sd3667;     17: t = 34'sd1833;
         18: t = 34'sd917;       19: t = 34'sd458;      20: t = 34'sd229;
         21: t = 34'sd115;       22: t = 34'sd57;       23: t = 34'sd29;
         24: t = 34'sd14;        25: t = 34'sd7;        26: t = 34'sd4;
         27: t = 34'sd2;         28: t = 34'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction
endpackage

// ===== rtl/core/qte_cordic_cell.sv =====
`timescale 1ns / 1ps
// One vectoring rotation; the pipeline register is inside the cell.
module qte_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic clock,
   input  logic signed [qte_pkg::OP_W-1:0] x_in,
   input  logic signed [qte_pkg::OP_W-1:0] y_in,
   input  qte_pkg::ang_type z_in,
   output logic signed [qte_pkg::OP_W-1:0] x_out,
   output logic signed [qte_pkg::OP_W-1:0] y_out,
   output qte_pkg::ang_type z_out
);
   logic signed [qte_pkg::OP_W-1:0] x_ff, y_ff, dx, dy;
   qte_pkg::ang_type z_ff;
   assign dx = y_in >>> STAGE;
   assign dy = x_in >>> STAGE;
   always_ff @(posedge clock) begin
      if (!y_in[qte_pkg::OP_W-1]) begin
         x_ff <= x_in + dx;
         y_ff <= y_in - dy;
         z_ff <= z_in + qte_pkg::atan_entry(STAGE);
      end else begin
         x_ff <= x_in - dx;
         y_ff <= y_in + dy;
         z_ff <= z_in - qte_pkg::atan_entry(STAGE);
      end
   end
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule

// ===== rtl/core/qte_atan2.sv =====
`timescale 1ns / 1ps
// Pipelined atan2: normalize (2 stages), quadrant fold, cell chain, round.
// Operands are IN_W bits signed, 38 by default.
module qte_atan2 #(
   parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
   parameter int IN_W = 38
) (
   input  logic clock,
   input  logic signed [IN_W-1:0] y_val,
   input  logic signed [IN_W-1:0] x_val,
   output logic signed [qte_pkg::ROLL_W-1:0] angle
);
   localparam int OW = qte_pkg::OP_W;
   localparam int SW = $clog2(IN_W + 31) + 1;
   localparam logic signed [IN_W+31:0] NEG_TOP = (IN_W+32)'(-(64'sd1 <<< 30));
   logic signed [IN_W-1:0] ya_ff, xa_ff;
   logic [IN_W-1:0] my, mx, mm;
   logic [SW-1:0] lead_in;
   logic signed [SW-1:0] sh_ff;
   logic zero_ff, zero2_ff, zero3_ff;
   logic signed [IN_W+31:0] yw, xw;
   logic signed [OW-1:0] ys_ff, xs_ff, xf_ff, yf_ff;
   qte_pkg::ang_type zf_ff;
   logic signed [OW-1:0] xc [0:CORDIC_STAGES];
   logic signed [OW-1:0] yc [0:CORDIC_STAGES];
   qte_pkg::ang_type zc [0:CORDIC_STAGES];
   logic zp [0:CORDIC_STAGES];
   qte_pkg::ang_type rnd;
   logic signed [qte_pkg::ANG_W-17:0] r;
   logic signed [qte_pkg::ROLL_W-1:0] angle_ff;

   assign my = y_val[IN_W-1] ? IN_W'(-y_val) : IN_W'(y_val);
   assign mx = x_val[IN_W-1] ? IN_W'(-x_val) : IN_W'(x_val);
   assign mm = (my > mx) ? my : mx;
   // find position of leading one of the larger magnitude
   always_comb begin
      lead_in = '0;
      for (int i = 0; i < IN_W; i++) if (mm[i]) lead_in = SW'(i);
   end
   always_ff @(posedge clock) begin
      ya_ff <= y_val;
      xa_ff <= x_val;
      sh_ff <= $signed(lead_in) - SW'(29);
      zero_ff <= (mm == '0);
   end
   // positive shift: floor right shift; negative: doubling
   always_comb begin
      yw = {{32{ya_ff[IN_W-1]}}, ya_ff};
      xw = {{32{xa_ff[IN_W-1]}}, xa_ff};
      if (sh_ff >= 0) begin
         yw = yw >>> sh_ff;
         xw = xw >>> sh_ff;
      end else begin
         yw = yw <<< (-sh_ff);
         xw = xw <<< (-sh_ff);
      end
      // a floored negative value can land on -2^30; take one more step down
      if (yw == NEG_TOP || xw == NEG_TOP) begin
         yw = yw >>> 1;
         xw = xw >>> 1;
      end
   end
   always_ff @(posedge clock) begin
      ys_ff <= OW'(yw);
      xs_ff <= OW'(xw);
      zero2_ff <= zero_ff;
      if (xs_ff[OW-1] && !ys_ff[OW-1]) begin
         xf_ff <= ys_ff; yf_ff <= -xs_ff;
         zf_ff <= qte_pkg::ang_type'(90) <<< qte_pkg::ANG_FRAC;
      end else if (xs_ff[OW-1]) begin
         xf_ff <= -ys_ff; yf_ff <= xs_ff;
         zf_ff <= -(qte_pkg::ang_type'(90) <<< qte_pkg::ANG_FRAC);
      end else begin
         xf_ff <= xs_ff; yf_ff <= ys_ff; zf_ff <= '0;
      end
      zero3_ff <= zero2_ff;
   end
   assign xc[0] = xf_ff;
   assign yc[0] = yf_ff;
   assign zc[0] = zf_ff;
   assign zp[0] = zero3_ff;
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      logic zp_ff;
      qte_cordic_cell #(.STAGE(g)) u_cell (
         .clock(clock), .x_in(xc[g]), .y_in(yc[g]), .z_in(zc[g]),
         .x_out(xc[g+1]), .y_out(yc[g+1]), .z_out(zc[g+1]));
      always_ff @(posedge clock) zp_ff <= zp[g];
      assign zp[g+1] = zp_ff;
   end
   assign rnd = zc[CORDIC_STAGES] + (qte_pkg::ang_type'(1) <<< (qte_pkg::ANG_FRAC - 7));
   assign r = rnd[qte_pkg::ANG_W-1:16];
   always_ff @(posedge clock) begin
      if (zp[CORDIC_STAGES]) angle_ff <= '0;
      else if (r > qte_pkg::ANG_LIM) angle_ff <= qte_pkg::ROLL_W'(qte_pkg::ANG_LIM);
      else if (r < -qte_pkg::ANG_LIM) angle_ff <= qte_pkg::ROLL_W'(-qte_pkg::ANG_LIM);
      else angle_ff <= qte_pkg::ROLL_W'(r);
   end
   assign angle = angle_ff;
endmodule

// ===== rtl/core/qte_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module qte_isqrt #(
   parameter int IN_W = 62
) (
   input  logic clock,
   input  logic [IN_W-1:0] radicand,
   output logic [IN_W/2-1:0] root
);
   localparam int N = IN_W / 2;
   logic [IN_W-1:0] rem [0:N];
   logic [N-1:0] res [0:N];
   assign rem[0] = radicand;
   assign res[0] = '0;
   for (genvar g = 0; g < N; g++) begin : g_bit
      localparam int B = N - 1 - g;
      logic [IN_W-1:0] rem_ff;
      logic [N-1:0] res_ff;
      logic [IN_W+1:0] trial;
      assign trial = ({2'b0, res[g]} << (B + 1)) + ((IN_W+2)'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if ({2'b0, rem[g]} >= trial) begin
            rem_ff <= rem[g] - IN_W'(trial);
            res_ff <= res[g] | (N'(1) << B);
         end else begin
            rem_ff <= rem[g];
            res_ff <= res[g];
         end
      end
      assign rem[g+1] = rem_ff;
      assign res[g+1] = res_ff;
   end
   assign root = res[N];
endmodule

// ===== rtl/core/quaternion_to_euler_angles_core.sv =====
`timescale 1ns / 1ps
// Quaternion (Q2.14) to Z-Y-X Euler angles in 1/64 degree. Takes a word every
// cycle (busy is always low) and gives each result on rsp_valid, for one
// cycle; the receiver cannot stall. The word passes through the product and
// sum stages, the pitch scaling and clamp, the pitch square-root chain of 31
// stages and one atan2 chain of CORDIC_STAGES cells; the roll and yaw chains
// run beside the pitch one.
module quaternion_to_euler_angles_core #(
   parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF,
   parameter int COMPONENT_WIDTH = qte_pkg::COMPONENT_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   output logic rsp_valid,
   output logic signed [qte_pkg::ROLL_W-1:0] rsp_roll_angle,
   output logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [qte_pkg::ROLL_W-1:0] rsp_yaw_angle,
   output logic rsp_degenerate
);
   localparam int CW = COMPONENT_WIDTH;
   localparam int PW = 2 * CW;
   localparam int SW = PW + 4;
   localparam int AW = SW + 2;
   localparam int SQ_LAT = 31;
   localparam int AT_LAT = CORDIC_STAGES + 4;
   // pitch path: scale(2) clamp(1) mult(1) isqrt(31) then atan2
   localparam int PITCH_PRE = 2 + 1 + 1 + SQ_LAT;
   localparam int LAT = 2 + PITCH_PRE + AT_LAT;
   localparam int DLY = PITCH_PRE;

   logic signed [PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, wx_ff, yz_ff, wz_ff, xy_ff, wy_ff, zx_ff;
   logic dg0_ff, dg1_ff;
   logic signed [SW-1:0] rn_in, rd_in, yn_in, yd_in, pn_in, pd_in;
   logic signed [AW-1:0] rn_ff, rd_ff, yn_ff, yd_ff, pn_ff, pd_ff;
   logic signed [AW-1:0] rn_d [0:DLY];
   logic signed [AW-1:0] rd_d [0:DLY];
   logic signed [AW-1:0] yn_d [0:DLY];
   logic signed [AW-1:0] yd_d [0:DLY];
   logic [LAT-1:0] vpipe_ff;
   logic [LAT-3:0] dpipe_ff;
   logic signed [qte_pkg::ROLL_W-1:0] roll_a, yaw_a, pitch_a;

   function automatic logic signed [PW-1:0] pr(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a * b);
      return (CW > 31) ? p / 4 : p;
   endfunction

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      ww_ff <= pr(req_quat_w, req_quat_w); xx_ff <= pr(req_quat_x, req_quat_x);
      yy_ff <= pr(req_quat_y, req_quat_y); zz_ff <= pr(req_quat_z, req_quat_z);
      wx_ff <= pr(req_quat_w, req_quat_x); yz_ff <= pr(req_quat_y, req_quat_z);
      wz_ff <= pr(req_quat_w, req_quat_z); xy_ff <= pr(req_quat_x, req_quat_y);
      wy_ff <= pr(req_quat_w, req_quat_y); zx_ff <= pr(req_quat_z, req_quat_x);
      dg0_ff <= (req_quat_w == '0) && (req_quat_x == '0) && (req_quat_y == '0)
                && (req_quat_z == '0);
   end

   assign rn_in = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
   assign rd_in = SW'(ww_ff) + SW'(zz_ff) - SW'(xx_ff) - SW'(yy_ff);
   assign yn_in = (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
   assign yd_in = SW'(ww_ff) + SW'(xx_ff) - SW'(yy_ff) - SW'(zz_ff);
   assign pn_in = (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
   assign pd_in = SW'(ww_ff) + SW'(xx_ff) + SW'(yy_ff) + SW'(zz_ff);

   always_ff @(posedge clock) begin
      rn_ff <= AW'(rn_in); rd_ff <= AW'(rd_in);
      yn_ff <= AW'(yn_in); yd_ff <= AW'(yd_in);
      pn_ff <= AW'(pn_in); pd_ff <= AW'(pd_in);
      dg1_ff <= dg0_ff;
   end

   // hold roll and yaw operands while the pitch scaling, clamp and square root run
   assign rn_d[0] = rn_ff; assign rd_d[0] = rd_ff;
   assign yn_d[0] = yn_ff; assign yd_d[0] = yd_ff;
   for (genvar g = 0; g < DLY; g++) begin : g_dly
      logic signed [AW-1:0] a_ff, b_ff, c_ff, d_ff;
      always_ff @(posedge clock) begin
         a_ff <= rn_d[g]; b_ff <= rd_d[g]; c_ff <= yn_d[g]; d_ff <= yd_d[g];
      end
      assign rn_d[g+1] = a_ff; assign rd_d[g+1] = b_ff;
      assign yn_d[g+1] = c_ff; assign yd_d[g+1] = d_ff;
   end

   // pitch: scale pair, clamp, c = isqrt((n-s)(n+s))
   localparam logic signed [AW+31:0] PNEG_TOP = (AW+32)'(-(64'sd1 <<< 30));
   logic [AW-1:0] pms, pmn, pmm;
   logic [6:0] plead;
   logic signed [6:0] psh_ff;
   logic signed [AW-1:0] ps1_ff, pn1_ff;
   logic signed [AW+31:0] psw, pnw;
   logic signed [qte_pkg::OP_W-1:0] ps2_ff, pn2_ff, ps3_ff, pn3_ff;
   logic pz1_ff, pz2_ff, pz3_ff;
   logic [61:0] rad_ff;
   logic [30:0] root;
   logic signed [qte_pkg::OP_W-1:0] ps_d [0:SQ_LAT + 1];
   logic pzd [0:SQ_LAT + 1];

   assign pms = pn_ff[AW-1] ? AW'(-pn_ff) : AW'(pn_ff);
   assign pmn = pd_ff[AW-1] ? AW'(-pd_ff) : AW'(pd_ff);
   assign pmm = (pms > pmn) ? pms : pmn;
   always_comb begin
      plead = '0;
      for (int i = 0; i < AW; i++) if (pmm[i]) plead = 7'(i);
   end
   always_ff @(posedge clock) begin
      ps1_ff <= pn_ff; pn1_ff <= pd_ff;
      psh_ff <= $signed(plead) - 7'sd29;
      pz1_ff <= (pd_ff <= 0);
   end
   always_comb begin
      psw = {{32{ps1_ff[AW-1]}}, ps1_ff};
      pnw = {{32{pn1_ff[AW-1]}}, pn1_ff};
      if (psh_ff >= 0) begin
         psw = psw >>> psh_ff; pnw = pnw >>> psh_ff;
      end else begin
         psw = psw <<< (-psh_ff); pnw = pnw <<< (-psh_ff);
      end
      // a floored negative value can land on -2^30; take one more step down
      if (psw == PNEG_TOP || pnw == PNEG_TOP) begin
         psw = psw >>> 1; pnw = pnw >>> 1;
      end
   end
   always_ff @(posedge clock) begin
      ps2_ff <= qte_pkg::OP_W'(psw); pn2_ff <= qte_pkg::OP_W'(pnw);
      pz2_ff <= pz1_ff;
      pn3_ff <= pn2_ff;
      if (ps2_ff > pn2_ff) ps3_ff <= pn2_ff;
      else if (ps2_ff < -pn2_ff) ps3_ff <= -pn2_ff;
      else ps3_ff <= ps2_ff;
      pz3_ff <= pz2_ff;
      rad_ff <= 62'($unsigned(31'(pn3_ff - ps3_ff)) * $unsigned(31'(pn3_ff + ps3_ff)));
   end
   assign ps_d[0] = ps3_ff;
   assign pzd[0] = pz3_ff;
   for (genvar g = 0; g < SQ_LAT + 1; g++) begin : g_pd
      logic signed [qte_pkg::OP_W-1:0] s_ff;
      logic z_ff;
      always_ff @(posedge clock) begin
         s_ff <= ps_d[g]; z_ff <= pzd[g];
      end
      assign ps_d[g+1] = s_ff;
      assign pzd[g+1] = z_ff;
   end
   qte_isqrt #(.IN_W(62)) u_sqrt (.clock(clock), .radicand(rad_ff), .root(root));

   logic signed [AW-1:0] pat_y, pat_x;
   assign pat_y = pzd[SQ_LAT + 1] ? '0 : AW'(ps_d[SQ_LAT + 1]);
   assign pat_x = pzd[SQ_LAT + 1] ? '0 : AW'({1'b0, root});

   qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .IN_W(AW)) u_roll (
      .clock(clock), .y_val(rn_d[DLY]), .x_val(rd_d[DLY]), .angle(roll_a));
   qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .IN_W(AW)) u_yaw (
      .clock(clock), .y_val(yn_d[DLY]), .x_val(yd_d[DLY]), .angle(yaw_a));
   qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .IN_W(AW)) u_pitch (
      .clock(clock), .y_val(pat_y), .x_val(pat_x), .angle(pitch_a));

   always_ff @(posedge clock) begin
      if (reset) vpipe_ff <= '0;
      else vpipe_ff <= {vpipe_ff[LAT-2:0], start};
      dpipe_ff <= {dpipe_ff[LAT-4:0], dg1_ff};
   end

   logic signed [qte_pkg::ROLL_W-1:0] pcl;
   assign pcl = (pitch_a > qte_pkg::PITCH_LIM) ? qte_pkg::ROLL_W'(qte_pkg::PITCH_LIM) :
                (pitch_a < -qte_pkg::PITCH_LIM) ? qte_pkg::ROLL_W'(-qte_pkg::PITCH_LIM) :
                pitch_a;
   assign rsp_valid = vpipe_ff[LAT-1];
   assign rsp_degenerate = dpipe_ff[LAT-3];
   assign rsp_roll_angle = rsp_degenerate ? '0 : roll_a;
   assign rsp_yaw_angle = rsp_degenerate ? '0 : yaw_a;
   assign rsp_pitch_angle = rsp_degenerate ? '0 : qte_pkg::PITCH_W'(pcl);

   a_lat: assert property (@(posedge clock) disable iff (reset)
      $past(vpipe_ff[LAT-2]) |-> rsp_valid) else $error("valid lost");
   a_deg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_roll_angle == '0 && rsp_yaw_angle == '0)
      else $error("degenerate angles");
   a_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= qte_pkg::PITCH_LIM
                    && rsp_pitch_angle >= -qte_pkg::PITCH_LIM)
      else $error("pitch range");
endmodule

// ===== tb/sv/tb_quaternion_to_euler_angles_core.sv =====
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles_core;
   localparam int CW = qte_pkg::COMPONENT_WIDTH_DEF;
   localparam int STAGES = qte_pkg::CORDIC_STAGES_DEF;
   localparam int ROLL_W = qte_pkg::ROLL_W;
   localparam int PITCH_W = qte_pkg::PITCH_W;
   localparam int ANG_FRAC = qte_pkg::ANG_FRAC;
   localparam int ANG_LIM = qte_pkg::ANG_LIM;
   localparam int PITCH_LIM = qte_pkg::PITCH_LIM;
   localparam int LATENCY_GUESS = 3 * STAGES + 31 + 40;
   localparam int WATCHDOG_LIMIT = 3 * STAGES + 31 + 2000;
   localparam int RANDOM_WORDS = 800;

   typedef struct packed {
      logic signed [CW-1:0] w;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ROLL_W-1:0]  yaw;
      logic                      degen;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CW-1:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic signed [ROLL_W-1:0]  rsp_roll_angle, rsp_yaw_angle;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;
   logic rsp_degenerate;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   bit     failed = 0;
   int     idle_cycles = 0;
   int     gap_left = 0;

   quaternion_to_euler_angles_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid), .rsp_roll_angle(rsp_roll_angle),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_degenerate(rsp_degenerate)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor shift right
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void normalize_pair(ref longint a, ref longint b);
      longint m;
      for (int g = 0; g < 70; g++) begin
         m = abs64(a) > abs64(b) ? abs64(a) : abs64(b);
         if (m >= (64'sd1 <<< 30)) begin
            a = shr_floor(a, 1);
            b = shr_floor(b, 1);
         end else if (m != 0 && m < (64'sd1 <<< 29)) begin
            a = a * 2;
            b = b * 2;
         end else begin
            break;
         end
      end
   endfunction

   function automatic longint vector_atan2(longint y, longint x);
      longint ang, t, dx, dy, r;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      normalize_pair(y, x);
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; ang = 64'sd90 <<< ANG_FRAC;
         end else begin
            t = x; x = -y; y = t; ang = -(64'sd90 <<< ANG_FRAC);
         end
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; ang += longint'(qte_pkg::atan_entry(i));
         end else begin
            x -= dx; y += dy; ang -= longint'(qte_pkg::atan_entry(i));
         end
      end
      r = shr_floor(ang + (64'sd1 <<< (ANG_FRAC - 7)), ANG_FRAC - 6);
      if (r > ANG_LIM) r = ANG_LIM;
      if (r < -ANG_LIM) r = -ANG_LIM;
      return r;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint ratio_asin(longint s, longint n);
      longint c, r;
      longint unsigned p;
      if (n <= 0) return 0;
      normalize_pair(s, n);
      if (s > n) s = n;
      if (s < -n) s = -n;
      p = longint'(n - s) * longint'(n + s);
      c = int_sqrt(p);
      r = vector_atan2(s, c);
      if (r > PITCH_LIM) r = PITCH_LIM;
      if (r < -PITCH_LIM) r = -PITCH_LIM;
      return r;
   endfunction

   function automatic euler_type quat_to_euler(quat_type q);
      euler_type e;
      longint w, x, y, z, ww, xx, yy, zz;
      w = q.w; x = q.x; y = q.y; z = q.z;
      e = '0;
      if (w == 0 && x == 0 && y == 0 && z == 0) begin
         e.degen = 1'b1;
      end else begin
         ww = w * w; xx = x * x; yy = y * y; zz = z * z;
         e.roll  = ROLL_W'(vector_atan2(2 * (w * x + y * z), ww + zz - xx - yy));
         e.yaw   = ROLL_W'(vector_atan2(2 * (w * z + x * y), ww + xx - yy - zz));
         e.pitch = PITCH_W'(ratio_asin(2 * (w * y - z * x), ww + xx + yy + zz));
      end
      return e;
   endfunction

   function automatic logic signed [CW-1:0] rand_component(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($signed($urandom_range(0, 32768)) - 16384);
         2: return CW'($signed($urandom_range(0, 64)) - 32);
         default: return CW'($signed($urandom_range(0, 2)) - 1) * 16'sd16384;
      endcase
   endfunction

   // drive: draw a gap per word, hold start until accepted
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         start <= 1'b0;
         gap_left <= $urandom_range(0, 11);
      end else if (start && !busy) begin
         pending_quats.pop_front();
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         gap_left <= (gap > 0) ? gap - 1 : 0;
         if (gap == 0 && pending_quats.size() > 0) begin
            {req_quat_w, req_quat_x, req_quat_y, req_quat_z} <= pending_quats[0];
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_quats.size() > 0) begin
            {req_quat_w, req_quat_x, req_quat_y, req_quat_z} <= pending_quats[0];
            start <= 1'b1;
         end
      end
   end

   // monitor: predict on accept, compare on strobe
   always @(posedge clock) begin
      euler_type got, exp_e;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (start && !busy) begin
            expected_angles.push_back(quat_to_euler(
               {req_quat_w, req_quat_x, req_quat_y, req_quat_z}));
         end
         if (rsp_valid) begin
            got = {rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle, rsp_degenerate};
            if (expected_angles.size() == 0) begin
               $display("%0t: unexpected word, actual %h", $time, got);
               failed = 1;
            end else begin
               exp_e = expected_angles.pop_front();
               if (got.roll !== exp_e.roll) begin
                  $display("%0t: roll expected %0d actual %0d", $time, exp_e.roll, got.roll);
                  failed = 1;
               end
               if (got.pitch !== exp_e.pitch) begin
                  $display("%0t: pitch expected %0d actual %0d", $time, exp_e.pitch,
                           got.pitch);
                  failed = 1;
               end
               if (got.yaw !== exp_e.yaw) begin
                  $display("%0t: yaw expected %0d actual %0d", $time, exp_e.yaw, got.yaw);
                  failed = 1;
               end
               if (got.degen !== exp_e.degen) begin
                  $display("%0t: degenerate expected %0b actual %0b", $time, exp_e.degen,
                           got.degen);
                  failed = 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_quaternion_to_euler_angles_core NOT OK");
         $finish;
      end
   end

   initial begin
      quat_type q;
      int mode;
      localparam logic signed [CW-1:0] MAXV = 16'sh7FFF;
      localparam logic signed [CW-1:0] MINV = 16'sh8000;
      localparam logic signed [CW-1:0] ONE = 16'sd16384;
      // zero quaternion, identity, axes, extremes, gimbal lock, 180
      pending_quats.push_back('{'0, '0, '0, '0});
      pending_quats.push_back('{ONE, '0, '0, '0});
      pending_quats.push_back('{-ONE, '0, '0, '0});
      pending_quats.push_back('{'0, ONE, '0, '0});
      pending_quats.push_back('{'0, '0, ONE, '0});
      pending_quats.push_back('{'0, '0, '0, ONE});
      pending_quats.push_back('{MAXV, MAXV, MAXV, MAXV});
      pending_quats.push_back('{MINV, MINV, MINV, MINV});
      pending_quats.push_back('{MINV, MAXV, MINV, MAXV});
      pending_quats.push_back('{MAXV, MINV, MAXV, MINV});
      pending_quats.push_back('{ONE, '0, ONE, '0});
      pending_quats.push_back('{ONE, '0, -ONE, '0});
      pending_quats.push_back('{'0, ONE, '0, ONE});
      pending_quats.push_back('{16'sd1, '0, '0, '0});
      pending_quats.push_back('{'0, '0, '0, -16'sd1});
      pending_quats.push_back('{'0, MINV, '0, '0});
      pending_quats.push_back('{16'sd11585, 16'sd11585, '0, '0});
      pending_quats.push_back('{-16'sd1, -16'sd1, -16'sd1, -16'sd1});
      pending_quats.push_back('{'0, '0, MINV, MAXV});
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         mode = $urandom_range(0, 3);
         q.w = rand_component(mode);
         q.x = rand_component(mode);
         q.y = rand_component(mode);
         q.z = rand_component(mode);
         pending_quats.push_back(q);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_quats.size() == 0);
      wait (expected_angles.size() == 0);
      repeat (LATENCY_GUESS) @(posedge clock);
      if (!failed && expected_angles.size() == 0) begin
         $display("tb_quaternion_to_euler_angles_core OK");
      end else begin
         $display("tb_quaternion_to_euler_angles_core NOT OK");
      end
      $finish;
   end
endmodule
